// ===== hdl/integer_literal_parser_defines.svh =====
// assertion macros for the integer literal parser checker
// no dependencies; included by the checker file only
`ifndef INTEGER_LITERAL_PARSER_DEFINES_SVH
`define INTEGER_LITERAL_PARSER_DEFINES_SVH

// same-cycle implication
`define ILP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ILP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/ilp_pkg.sv =====
// shared types and constants of the integer literal parser
// no dependencies; used by every module of the block
package ilp_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 64;
   localparam int VALUE_PORT_W        = 64;
   localparam int CHAR_W              = 8;
   localparam int STATUS_W            = 2;
   localparam int MODE_W              = 2;
   localparam int RADIX_W             = 5;
   localparam int DIGIT_W             = 6;
   localparam int PHASE_W             = 3;

   // queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_IDX_MODE  = 1'b0;
   localparam logic REG_IDX_RADIX = 1'b1;
   localparam logic [MODE_W-1:0]  MODE_RESET  = 2'd2;
   localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

   // parse modes
   localparam logic [MODE_W-1:0] MODE_UNSIGNED = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SIGNED   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PREFIX   = 2'd2;

   // result status
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_DIGIT = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd3;

   // parser phases
   localparam logic [PHASE_W-1:0] PH_START  = 3'd0;
   localparam logic [PHASE_W-1:0] PH_SIGNED = 3'd1;
   localparam logic [PHASE_W-1:0] PH_ZERO   = 3'd2;
   localparam logic [PHASE_W-1:0] PH_NEED   = 3'd3;
   localparam logic [PHASE_W-1:0] PH_DIGITS = 3'd4;
   localparam logic [PHASE_W-1:0] PH_SKIP   = 3'd5;

   // bases
   localparam logic [RADIX_W-1:0] BASE_MIN = 5'd2;
   localparam logic [RADIX_W-1:0] BASE_QUA = 5'd4;
   localparam logic [RADIX_W-1:0] BASE_OCT = 5'd8;
   localparam logic [RADIX_W-1:0] BASE_DEC = 5'd10;
   localparam logic [RADIX_W-1:0] BASE_MAX = 5'd16;

   // characters
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
   localparam logic [CHAR_W-1:0] CH_B     = 8'h62;
   localparam logic [CHAR_W-1:0] CH_Q     = 8'h71;
   localparam logic [CHAR_W-1:0] CH_O     = 8'h6F;
   localparam logic [CHAR_W-1:0] CH_D     = 8'h64;
   localparam logic [CHAR_W-1:0] CH_X     = 8'h78;

   // one classified text word
   typedef struct packed {
      logic                 eot;
      logic                 is_dig;
      logic [DIGIT_W-1:0]   dval;
      logic                 is_plus;
      logic                 is_minus;
      logic                 is_zero;
      logic                 is_pfx;
      logic [RADIX_W-1:0]   pfx_base;
   } class_type;

   // configuration seen by the back end
   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [RADIX_W-1:0] radix;
   } cfg_type;

endpackage

// ===== hdl/ilp_front.sv =====
// front end: classifies one text word into digit, sign and prefix flags
// depends on ilp_pkg
module ilp_front (
   input  logic [ilp_pkg::CHAR_W-1:0] character,
   input  logic                       end_of_text,
   output ilp_pkg::class_type         cls
);

   always_comb begin
      cls          = '0;
      cls.eot      = end_of_text;
      cls.is_plus  = (character == ilp_pkg::CH_PLUS);
      cls.is_minus = (character == ilp_pkg::CH_MINUS);
      cls.is_zero  = (character == ilp_pkg::CH_ZERO);
      // raw digit value 0..35, before the base check
      if (character inside {[ilp_pkg::CH_ZERO:ilp_pkg::CH_NINE]}) begin
         cls.is_dig = 1'b1;
         cls.dval   = ilp_pkg::DIGIT_W'(character - ilp_pkg::CH_ZERO);
      end else if (character inside {[ilp_pkg::CH_LA:ilp_pkg::CH_LZ]}) begin
         cls.is_dig = 1'b1;
         cls.dval   = ilp_pkg::DIGIT_W'(character - ilp_pkg::CH_LA + 8'd10);
      end else if (character inside {[ilp_pkg::CH_UA:ilp_pkg::CH_UZ]}) begin
         cls.is_dig = 1'b1;
         cls.dval   = ilp_pkg::DIGIT_W'(character - ilp_pkg::CH_UA + 8'd10);
      end
      // radix prefix letters
      case (character)
         ilp_pkg::CH_B: begin
            cls.is_pfx   = 1'b1;
            cls.pfx_base = ilp_pkg::BASE_MIN;
         end
         ilp_pkg::CH_Q: begin
            cls.is_pfx   = 1'b1;
            cls.pfx_base = ilp_pkg::BASE_QUA;
         end
         ilp_pkg::CH_O: begin
            cls.is_pfx   = 1'b1;
            cls.pfx_base = ilp_pkg::BASE_OCT;
         end
         ilp_pkg::CH_D: begin
            cls.is_pfx   = 1'b1;
            cls.pfx_base = ilp_pkg::BASE_DEC;
         end
         ilp_pkg::CH_X: begin
            cls.is_pfx   = 1'b1;
            cls.pfx_base = ilp_pkg::BASE_MAX;
         end
         default: begin
            cls.is_pfx   = 1'b0;
            cls.pfx_base = ilp_pkg::BASE_DEC;
         end
      endcase
   end

endmodule

// ===== hdl/ilp_queue.sv =====
// short queue of classified words between front and back
// depends on ilp_pkg
module ilp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ilp_pkg::class_type push_word,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output ilp_pkg::class_type head_word
);

   ilp_pkg::class_type              slot_ff [ilp_pkg::QDEPTH];
   logic [ilp_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [ilp_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [ilp_pkg::QCNT_W-1:0]      cnt_ff, cnt_in;
   logic                            do_push, do_pop;

   assign full       = (cnt_ff == ilp_pkg::QCNT_W'(ilp_pkg::QDEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_word  = slot_ff[rd_ptr_ff];
   assign do_push    = push & ~full;
   assign do_pop     = pop & head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ===== hdl/ilp_back.sv =====
// back end: parser state machine, digit multiply-add, result register
// depends on ilp_pkg
module ilp_back #(
   parameter int VALUE_WIDTH = ilp_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ilp_pkg::cfg_type                  cfg,
   input  logic                              q_valid,
   input  ilp_pkg::class_type                q_word,
   output logic                              q_pop,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output logic [ilp_pkg::VALUE_PORT_W-1:0]  rsp_value,
   output logic [ilp_pkg::STATUS_W-1:0]      rsp_status
);

   localparam int PW = VALUE_WIDTH + ilp_pkg::DIGIT_W;

   logic [ilp_pkg::PHASE_W-1:0]      phase_ff, phase_in;
   logic                             neg_ff, neg_in;
   logic [ilp_pkg::RADIX_W-1:0]      base_ff, base_in;
   logic [VALUE_WIDTH-1:0]           acc_ff, acc_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [ilp_pkg::VALUE_PORT_W-1:0] rsp_value_ff;
   logic [ilp_pkg::STATUS_W-1:0]     rsp_status_ff;

   logic [ilp_pkg::MODE_W-1:0]       mode;
   logic [ilp_pkg::RADIX_W-1:0]      crad, start_base, base_dig;
   logic [VALUE_WIDTH-1:0]           mask, half, lim, acc_src, res_val;
   logic [PW-1:0]                    prod;
   logic                             dig_ok, ovf, take, emit, go;
   logic [ilp_pkg::STATUS_W-1:0]     st;

   assign go    = q_valid & (~rsp_valid_ff | ~rsp_stall);
   assign q_pop = go;

   always_comb begin
      mode = (cfg.mode >= ilp_pkg::MODE_PREFIX) ? ilp_pkg::MODE_PREFIX : cfg.mode;
      if (cfg.radix < ilp_pkg::BASE_MIN) begin
         crad = ilp_pkg::BASE_MIN;
      end else if (cfg.radix > ilp_pkg::BASE_MAX) begin
         crad = ilp_pkg::BASE_MAX;
      end else begin
         crad = cfg.radix;
      end
      start_base = (mode == ilp_pkg::MODE_PREFIX) ? ilp_pkg::BASE_DEC : crad;
      if (phase_ff == ilp_pkg::PH_START) begin
         base_dig = start_base;
      end else if (phase_ff == ilp_pkg::PH_ZERO) begin
         base_dig = ilp_pkg::BASE_DEC;
      end else begin
         base_dig = base_ff;
      end
      dig_ok = q_word.is_dig && (q_word.dval < {1'b0, base_dig});

      // exact limit check on acc*base+d
      mask = '1;
      half = mask >> 1;
      if (mode == ilp_pkg::MODE_UNSIGNED) begin
         lim = mask;
      end else if (neg_ff) begin
         lim = half + 1'b1;
      end else begin
         lim = half;
      end
      acc_src = (phase_ff == ilp_pkg::PH_DIGITS) ? acc_ff : '0;
      prod    = PW'(acc_src) * PW'(base_dig) + PW'(q_word.dval);
      ovf     = (prod > PW'(lim));

      phase_in = phase_ff;
      neg_in   = neg_ff;
      base_in  = (phase_ff == ilp_pkg::PH_START) ? start_base : base_ff;
      acc_in   = acc_ff;
      take     = 1'b0;
      emit     = 1'b0;
      st       = ilp_pkg::ST_OK;

      if (q_word.eot) begin
         emit = 1'b1;
         case (phase_ff)
            ilp_pkg::PH_ZERO:   st = ilp_pkg::ST_OK;
            ilp_pkg::PH_DIGITS: st = ilp_pkg::ST_OK;
            ilp_pkg::PH_SKIP:   st = ilp_pkg::ST_OVERFLOW;
            default:            st = ilp_pkg::ST_NOT_DIGIT;
         endcase
      end else begin
         case (phase_ff)
            ilp_pkg::PH_START, ilp_pkg::PH_SIGNED, ilp_pkg::PH_NEED: begin
               if (phase_ff == ilp_pkg::PH_START && mode != ilp_pkg::MODE_UNSIGNED &&
                   (q_word.is_plus || q_word.is_minus)) begin
                  neg_in   = q_word.is_minus;
                  phase_in = ilp_pkg::PH_SIGNED;
               end else if (phase_ff != ilp_pkg::PH_NEED && mode == ilp_pkg::MODE_PREFIX &&
                            q_word.is_zero) begin
                  phase_in = ilp_pkg::PH_ZERO;
               end else if (!dig_ok) begin
                  emit = 1'b1;
                  st   = ilp_pkg::ST_NOT_DIGIT;
               end else begin
                  take = 1'b1;
               end
            end
            ilp_pkg::PH_ZERO: begin
               if (q_word.is_pfx) begin
                  base_in  = q_word.pfx_base;
                  phase_in = ilp_pkg::PH_NEED;
               end else begin
                  base_in  = ilp_pkg::BASE_DEC;
                  acc_in   = '0;
                  phase_in = ilp_pkg::PH_DIGITS;
                  if (!dig_ok) begin
                     emit = 1'b1;
                  end else begin
                     take = 1'b1;
                  end
               end
            end
            ilp_pkg::PH_DIGITS: begin
               if (!dig_ok) begin
                  emit = 1'b1;
               end else begin
                  take = 1'b1;
               end
            end
            ilp_pkg::PH_SKIP: begin
               if (!dig_ok) begin
                  emit = 1'b1;
                  st   = ilp_pkg::ST_OVERFLOW;
               end
            end
            default: begin
               // unused phase codes restart the number
               phase_in = ilp_pkg::PH_START;
               neg_in   = 1'b0;
               acc_in   = '0;
               base_in  = start_base;
            end
         endcase
      end

      if (take) begin
         if (ovf) begin
            phase_in = ilp_pkg::PH_SKIP;
         end else begin
            acc_in   = prod[VALUE_WIDTH-1:0];
            phase_in = ilp_pkg::PH_DIGITS;
         end
      end

      res_val = '0;
      if (st == ilp_pkg::ST_OK) begin
         res_val = neg_ff ? (~acc_ff + 1'b1) : acc_ff;
      end else if (st == ilp_pkg::ST_OVERFLOW && neg_ff && mode != ilp_pkg::MODE_UNSIGNED) begin
         st = ilp_pkg::ST_UNDERFLOW;
      end

      if (emit) begin
         phase_in = ilp_pkg::PH_START;
         neg_in   = 1'b0;
         acc_in   = '0;
         base_in  = start_base;
      end

      if (go) begin
         rsp_valid_in = emit;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ilp_pkg::PH_START;
         neg_ff       <= 1'b0;
         base_ff      <= ilp_pkg::BASE_DEC;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (go) begin
            phase_ff <= phase_in;
            neg_ff   <= neg_in;
            base_ff  <= base_in;
            acc_ff   <= acc_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go && emit) begin
         rsp_value_ff  <= ilp_pkg::VALUE_PORT_W'(res_val);
         rsp_status_ff <= st;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// ===== hdl/integer_literal_parser.sv =====
// integer literal parser: top level with configuration registers
// depends on ilp_pkg, ilp_front, ilp_queue and ilp_back
//
// usage
//   req channel: one text word per accept (req_character, req_end_of_text),
//   accepted at a clock edge with req_valid high and req_stall low
//   rsp channel: one word per finished number (rsp_value, rsp_status),
//   taken at an edge with rsp_valid high and rsp_stall low
//   csr port: apb-style, parse_mode at byte 0, radix at byte 4; write only
//   while the block is idle; pready is tied high
// throughput: one text word per cycle sustained unless a stalled result holds the back end;
//   each digit is one multiply-add by the base plus an exact limit compare in the back end
// result path: a terminating word is written into the queue, then the back end steps on it
//   and registers its result
// reset: synchronous, clears queue, parser state and the result valid flag;
//   parse_mode returns to 2 (prefix mode) and radix to 10
// stall: a stalled result holds in the output register while the back end
//   waits; the 4-word queue absorbs the front, and req_stall rises once it
//   is full
module integer_literal_parser #(
   parameter int VALUE_WIDTH = ilp_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // text words in
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [ilp_pkg::CHAR_W-1:0]         req_character,
   input  logic                               req_end_of_text,
   // results out
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [ilp_pkg::VALUE_PORT_W-1:0]   rsp_value,
   output logic [ilp_pkg::STATUS_W-1:0]       rsp_status,
   // configuration
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ilp_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [ilp_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [ilp_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   logic [ilp_pkg::MODE_W-1:0]  mode_ff, mode_in;
   logic [ilp_pkg::RADIX_W-1:0] radix_ff, radix_in;
   logic                        csr_wr;
   logic                        reg_idx;
   ilp_pkg::cfg_type            cfg;
   ilp_pkg::class_type          front_word, head_word;
   logic                        q_full, q_valid, q_pop;

   // register file: word address picks the register
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[2];

   always_comb begin
      mode_in  = mode_ff;
      radix_in = radix_ff;
      if (csr_wr) begin
         case (reg_idx)
            ilp_pkg::REG_IDX_MODE:  mode_in  = csr_pwdata[ilp_pkg::MODE_W-1:0];
            ilp_pkg::REG_IDX_RADIX: radix_in = csr_pwdata[ilp_pkg::RADIX_W-1:0];
            default: ;
         endcase
      end
      case (reg_idx)
         ilp_pkg::REG_IDX_MODE:  csr_prdata = ilp_pkg::CSR_DATA_W'(mode_ff);
         ilp_pkg::REG_IDX_RADIX: csr_prdata = ilp_pkg::CSR_DATA_W'(radix_ff);
         default:                csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= ilp_pkg::MODE_RESET;
         radix_ff <= ilp_pkg::RADIX_RESET;
      end else begin
         mode_ff  <= mode_in;
         radix_ff <= radix_in;
      end
   end

   assign cfg.mode  = mode_ff;
   assign cfg.radix = radix_ff;

   // front: classify each incoming word
   ilp_front u_front (
      .character   (req_character),
      .end_of_text (req_end_of_text),
      .cls         (front_word)
   );

   // queue decouples front from back
   assign req_stall = q_full;

   ilp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid),
      .push_word  (front_word),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_word  (head_word)
   );

   // back: one word per cycle through the parser state, unless a stalled result holds it
   ilp_back #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_valid    (q_valid),
      .q_word     (head_word),
      .q_pop      (q_pop),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status)
   );

endmodule

// ===== hdl/ilp_checker.sv =====
// port-level checks of the integer literal parser, bound to the top level
// depends on ilp_pkg and integer_literal_parser_defines.svh
`include "integer_literal_parser_defines.svh"

module ilp_checker #(
   parameter int VALUE_WIDTH = ilp_pkg::VALUE_WIDTH_DEFAULT
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [ilp_pkg::VALUE_PORT_W-1:0] rsp_value,
   input logic [ilp_pkg::STATUS_W-1:0]     rsp_status
);

   // a stalled result word holds
   `ILP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_value) && $stable(rsp_status), "result changed under stall")

   // error results carry a zero value
   `ILP_ASSERT_IMPLY(a_err_zero, clock, reset, rsp_valid && rsp_status != ilp_pkg::ST_OK, rsp_value == '0, "nonzero value with error status")

   // value never exceeds the configured width
   `ILP_ASSERT_IMPLY(a_val_width, clock, reset, rsp_valid, (rsp_value >> VALUE_WIDTH) == '0, "value wider than VALUE_WIDTH")

endmodule

bind integer_literal_parser ilp_checker #(
   .VALUE_WIDTH (VALUE_WIDTH)
) u_ilp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_value  (rsp_value),
   .rsp_status (rsp_status)
);

// ===== tb/integer_literal_parser_tb.sv =====
// self-checking testbench for the integer literal parser
// holds its own model of the parser and checks every result word field by field
// depends on ilp_pkg and integer_literal_parser
`timescale 1ns / 100ps

module integer_literal_parser_tb;

   localparam int VALUE_W = ilp_pkg::VALUE_WIDTH_DEFAULT;
   localparam logic [63:0] WIDTH_MASK = {64{1'b1}} >> (64 - VALUE_W);
   // extra wait after the last pending number, for the queue to empty
   localparam int DRAIN_CYCLES = 12;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_WORDS = 600;
   localparam int PHASES = 10;

   // expected numbers plus a word-by-word model of the parser state
   class literal_scoreboard;
      typedef struct packed {
         logic [63:0]                  value;
         logic [ilp_pkg::STATUS_W-1:0] status;
      } number_type;

      number_type                   pending_numbers[$];
      logic [ilp_pkg::MODE_W-1:0]   mode_reg;
      logic [ilp_pkg::RADIX_W-1:0]  radix_reg;
      logic [ilp_pkg::PHASE_W-1:0]  phase;
      bit                           negative;
      logic [ilp_pkg::RADIX_W-1:0]  base;
      logic [63:0]                  magnitude;
      int                           mismatches;

      function new();
         mode_reg = ilp_pkg::MODE_RESET;
         radix_reg = ilp_pkg::RADIX_RESET;
         mismatches = 0;
         start_number();
      endfunction

      function logic [ilp_pkg::MODE_W-1:0] eff_mode();
         return (mode_reg >= ilp_pkg::MODE_PREFIX) ? ilp_pkg::MODE_PREFIX : mode_reg;
      endfunction

      function logic [ilp_pkg::RADIX_W-1:0] fixed_base();
         if (eff_mode() == ilp_pkg::MODE_PREFIX) return ilp_pkg::BASE_DEC;
         if (radix_reg < ilp_pkg::BASE_MIN) return ilp_pkg::BASE_MIN;
         if (radix_reg > ilp_pkg::BASE_MAX) return ilp_pkg::BASE_MAX;
         return radix_reg;
      endfunction

      function void start_number();
         phase = ilp_pkg::PH_START;
         negative = 0;
         magnitude = '0;
         base = fixed_base();
      endfunction

      function void write_reg(logic idx, logic [31:0] data);
         if (idx == ilp_pkg::REG_IDX_MODE) begin
            mode_reg = data[ilp_pkg::MODE_W-1:0];
         end else begin
            radix_reg = data[ilp_pkg::RADIX_W-1:0];
         end
      endfunction

      function logic [63:0] magnitude_limit();
         if (eff_mode() == ilp_pkg::MODE_UNSIGNED) return WIDTH_MASK;
         return negative ? (WIDTH_MASK >> 1) + 64'd1 : (WIDTH_MASK >> 1);
      endfunction

      // digit value below the active base, or -1
      function int digit_value(logic [7:0] c);
         int v;
         if (c >= ilp_pkg::CH_ZERO && c <= ilp_pkg::CH_NINE) begin
            v = c - ilp_pkg::CH_ZERO;
         end else if (c >= ilp_pkg::CH_LA && c <= ilp_pkg::CH_LZ) begin
            v = c - ilp_pkg::CH_LA + 10;
         end else if (c >= ilp_pkg::CH_UA && c <= ilp_pkg::CH_UZ) begin
            v = c - ilp_pkg::CH_UA + 10;
         end else begin
            return -1;
         end
         return (v < int'(base)) ? v : -1;
      endfunction

      // exact limit check, then multiply-add
      function void accumulate(int d);
         logic [63:0] lim;
         lim = magnitude_limit();
         if (magnitude > (lim - 64'(d)) / 64'(base)) begin
            phase = ilp_pkg::PH_SKIP;
         end else begin
            magnitude = magnitude * 64'(base) + 64'(d);
            phase = ilp_pkg::PH_DIGITS;
         end
      endfunction

      function void finish_number(logic [ilp_pkg::STATUS_W-1:0] status);
         number_type n;
         n.value = '0;
         n.status = status;
         if (status == ilp_pkg::ST_OK) begin
            n.value = (negative ? (64'd0 - magnitude) : magnitude) & WIDTH_MASK;
         end else if (status == ilp_pkg::ST_OVERFLOW && negative &&
                      eff_mode() != ilp_pkg::MODE_UNSIGNED) begin
            n.status = ilp_pkg::ST_UNDERFLOW;
         end
         pending_numbers.push_back(n);
         start_number();
      endfunction

      function void first_digit(logic [7:0] c);
         int d;
         if (phase != ilp_pkg::PH_NEED && eff_mode() == ilp_pkg::MODE_PREFIX &&
             c == ilp_pkg::CH_ZERO) begin
            phase = ilp_pkg::PH_ZERO;
            return;
         end
         d = digit_value(c);
         if (d < 0) begin
            finish_number(ilp_pkg::ST_NOT_DIGIT);
         end else begin
            magnitude = '0;
            accumulate(d);
         end
      endfunction

      // one accepted text word
      function void note_text_word(logic [7:0] c, logic eot);
         int d;
         if (phase == ilp_pkg::PH_START) base = fixed_base();
         if (eot) begin
            case (phase)
               ilp_pkg::PH_ZERO: begin
                  magnitude = '0;
                  finish_number(ilp_pkg::ST_OK);
               end
               ilp_pkg::PH_DIGITS: finish_number(ilp_pkg::ST_OK);
               ilp_pkg::PH_SKIP:   finish_number(ilp_pkg::ST_OVERFLOW);
               default:            finish_number(ilp_pkg::ST_NOT_DIGIT);
            endcase
            return;
         end
         case (phase)
            ilp_pkg::PH_START: begin
               if (eff_mode() != ilp_pkg::MODE_UNSIGNED &&
                   (c == ilp_pkg::CH_PLUS || c == ilp_pkg::CH_MINUS)) begin
                  negative = (c == ilp_pkg::CH_MINUS);
                  phase = ilp_pkg::PH_SIGNED;
               end else begin
                  first_digit(c);
               end
            end
            ilp_pkg::PH_SIGNED, ilp_pkg::PH_NEED: first_digit(c);
            ilp_pkg::PH_ZERO: begin
               case (c)
                  ilp_pkg::CH_B: begin base = ilp_pkg::BASE_MIN; phase = ilp_pkg::PH_NEED; end
                  ilp_pkg::CH_Q: begin base = ilp_pkg::BASE_QUA; phase = ilp_pkg::PH_NEED; end
                  ilp_pkg::CH_O: begin base = ilp_pkg::BASE_OCT; phase = ilp_pkg::PH_NEED; end
                  ilp_pkg::CH_D: begin base = ilp_pkg::BASE_DEC; phase = ilp_pkg::PH_NEED; end
                  ilp_pkg::CH_X: begin base = ilp_pkg::BASE_MAX; phase = ilp_pkg::PH_NEED; end
                  default: begin
                     // lone zero: the word is the next decimal digit or the end
                     base = ilp_pkg::BASE_DEC;
                     magnitude = '0;
                     phase = ilp_pkg::PH_DIGITS;
                     d = digit_value(c);
                     if (d < 0) begin
                        finish_number(ilp_pkg::ST_OK);
                     end else begin
                        accumulate(d);
                     end
                  end
               endcase
            end
            ilp_pkg::PH_DIGITS: begin
               d = digit_value(c);
               if (d < 0) begin
                  finish_number(ilp_pkg::ST_OK);
               end else begin
                  accumulate(d);
               end
            end
            ilp_pkg::PH_SKIP: begin
               if (digit_value(c) < 0) finish_number(ilp_pkg::ST_OVERFLOW);
            end
            default: start_number();
         endcase
      endfunction

      task report_mismatch(string msg);
         if (mismatches < 200) $display("mismatch: %s", msg);
         mismatches++;
      endtask

      task check_number(logic [63:0] value, logic [ilp_pkg::STATUS_W-1:0] status);
         number_type n;
         if (pending_numbers.size() == 0) begin
            report_mismatch($sformatf("result word %h status %0d with nothing pending",
                                      value, status));
            return;
         end
         n = pending_numbers.pop_front();
         if (value !== n.value)
            report_mismatch($sformatf("value %h, wanted %h", value, n.value));
         if (status !== n.status)
            report_mismatch($sformatf("status %0d, wanted %0d", status, n.status));
      endtask
   endclass

   // clock, reset and every input of the block start at known values
   logic                                clock = 0;
   logic                                reset = 1;
   logic                                req_valid = 0;
   logic                                req_stall;
   logic [ilp_pkg::CHAR_W-1:0]          req_character = '0;
   logic                                req_end_of_text = 0;
   logic                                rsp_valid;
   logic                                rsp_stall = 0;
   logic [ilp_pkg::VALUE_PORT_W-1:0]    rsp_value;
   logic [ilp_pkg::STATUS_W-1:0]        rsp_status;
   logic                                csr_psel = 0;
   logic                                csr_penable = 0;
   logic                                csr_pwrite = 0;
   logic [ilp_pkg::CSR_ADDR_W-1:0]      csr_paddr = '0;
   logic [ilp_pkg::CSR_DATA_W-1:0]      csr_pwdata = '0;
   logic [ilp_pkg::CSR_DATA_W-1:0]      csr_prdata;
   logic                                csr_pready;

   literal_scoreboard sb = new();
   int  words_sent = 0;
   int  cycle_count = 0;
   int  stall_left = 0;
   bit  calm = 0;     // no idling on either side near the end

   // register settings per phase, extremes and out-of-range values included
   int unsigned mode_plan  [PHASES] = '{2, 0, 0, 1, 1, 3, 0, 1, 2, 1};
   int unsigned radix_plan [PHASES] = '{10, 2, 16, 10, 7, 5, 0, 31, 16, 17};

   integer_literal_parser uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_character   (req_character),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_value       (rsp_value),
      .rsp_status      (rsp_status),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // result side: random stall bursts, free stretches in between
   always @(negedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 0;
      end else if (stall_left != 0) begin
         rsp_stall <= 1;
         stall_left--;
      end else begin
         rsp_stall <= 0;
         if ($urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 13);
      end
   end

   // every result word taken is checked against the oldest pending number
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_number(rsp_value, rsp_status);
   end

   // text side drops req_valid and idles for a span set by n
   task automatic hold_off(int n);
      @(negedge clock);
      req_valid <= 0;
      repeat (n - 1) @(negedge clock);
   endtask

   // present one text word and hold it until taken
   task automatic send_word(logic [7:0] c, logic eot);
      @(negedge clock);
      req_valid <= 1;
      req_character <= c;
      req_end_of_text <= eot;
      do @(posedge clock); while (req_stall);
      sb.note_text_word(c, eot);
      words_sent++;
      if (!calm && $urandom_range(0, 7) == 0) hold_off($urandom_range(1, 13));
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
   endtask

   // stop sending until every pending number has come out and the queue is empty
   task automatic drain();
      @(negedge clock);
      req_valid <= 0;
      while (sb.pending_numbers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write a register (setup then access), then read it back
   task automatic program_register(logic idx, logic [31:0] value);
      logic [31:0] mask;
      logic [31:0] data;
      mask = (idx == ilp_pkg::REG_IDX_MODE) ? 32'((1 << ilp_pkg::MODE_W) - 1)
                                            : 32'((1 << ilp_pkg::RADIX_W) - 1);
      // junk in the unused bits should be dropped
      data = ($urandom & ~mask) | (value & mask);
      @(negedge clock);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_penable <= 0;
      csr_pwrite <= 0;
      @(negedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== (data & mask))
         sb.report_mismatch($sformatf("register %0d reads %h, wanted %h",
                                      idx, csr_prdata, data & mask));
      @(negedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
   endtask

   function automatic logic [7:0] digit_char(int d);
      if (d < 10) return ilp_pkg::CH_ZERO + 8'(d);
      return ($urandom_range(0, 1) ? ilp_pkg::CH_LA : ilp_pkg::CH_UA) + 8'(d - 10);
   endfunction

   // characters that end a number in any base up to sixteen
   function automatic logic [7:0] stop_char();
      case ($urandom_range(0, 7))
         0: return 8'h20;
         1: return 8'h2C;
         2: return 8'h3B;
         3: return 8'h29;
         4: return 8'h00;
         5: return 8'hFF;
         6: return 8'h7A;
         default: return 8'h5F;
      endcase
   endfunction

   // one literal: optional sign and prefix, digits aimed at the limits, terminator
   task automatic send_literal();
      logic [63:0] target, top;
      logic [7:0]  text[$];
      int          radix_now;
      bit          overshoot;
      radix_now = sb.fixed_base();
      overshoot = 0;
      if (sb.eff_mode() != ilp_pkg::MODE_UNSIGNED) begin
         if ($urandom_range(0, 2) == 0)
            send_word($urandom_range(0, 1) ? ilp_pkg::CH_MINUS : ilp_pkg::CH_PLUS, 1'b0);
      end else if ($urandom_range(0, 24) == 0) begin
         // stray sign where none is allowed
         send_word(ilp_pkg::CH_MINUS, 1'b0);
      end
      if (sb.eff_mode() == ilp_pkg::MODE_PREFIX && $urandom_range(0, 3) != 0) begin
         send_word(ilp_pkg::CH_ZERO, 1'b0);
         case ($urandom_range(0, 4))
            0: begin send_word(ilp_pkg::CH_B, 1'b0); radix_now = ilp_pkg::BASE_MIN; end
            1: begin send_word(ilp_pkg::CH_Q, 1'b0); radix_now = ilp_pkg::BASE_QUA; end
            2: begin send_word(ilp_pkg::CH_O, 1'b0); radix_now = ilp_pkg::BASE_OCT; end
            3: begin send_word(ilp_pkg::CH_D, 1'b0); radix_now = ilp_pkg::BASE_DEC; end
            default: begin send_word(ilp_pkg::CH_X, 1'b0); radix_now = ilp_pkg::BASE_MAX; end
         endcase
      end
      top = sb.magnitude_limit();
      case ($urandom_range(0, 5))
         0: target = 64'($urandom_range(0, 20));
         1: target = {$urandom, $urandom};
         2: target = top;
         3: target = top - 64'd1;
         4: begin
            // one past the limit
            if (top == WIDTH_MASK) begin
               target = top;
               overshoot = 1;
            end else begin
               target = top + 64'd1;
            end
         end
         default: target = {$urandom, $urandom} >> $urandom_range(0, 63);
      endcase
      if ($urandom_range(0, 7) == 0) overshoot = 1;
      do begin
         text.push_front(digit_char(int'(target % 64'(radix_now))));
         target = target / 64'(radix_now);
      end while (target != 0);
      if ($urandom_range(0, 5) == 0) text.push_front(ilp_pkg::CH_ZERO);
      if (overshoot) text.push_back(digit_char($urandom_range(0, radix_now - 1)));
      // broken literal: sign or prefix with no digits behind it
      if ($urandom_range(0, 15) == 0) text.delete();
      foreach (text[i]) send_word(text[i], 1'b0);
      if ($urandom_range(0, 3) == 0) begin
         send_word(8'($urandom_range(0, 255)), 1'b1);
      end else begin
         send_word(stop_char(), 1'b0);
      end
   endtask

   initial begin
      int phase_end;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed words in the reset setting: prefix mode, base ten
      send_word(8'hA5, 1'b1);   // end of text at the start of a number
      send_word(8'hFF, 1'b0);   // top byte is not a digit
      send_word(8'h00, 1'b0);   // nor is zero
      send_text("-0,");         // minus zero
      send_text("0x;");         // prefix with no digit behind it
      send_text("+?");          // sign with no digit behind it
      send_text("07 ");         // lone zero read as a decimal digit
      send_text("0b");
      send_word(8'h00, 1'b1);   // end of text right after a prefix
      send_text("0z");          // lone zero ended by a letter
      send_word(ilp_pkg::CH_ZERO, 1'b0);
      send_word(8'h5A, 1'b1);   // lone zero ended by end of text
      drain();

      // random literals, one register setting per phase
      for (int p = 0; p < PHASES; p++) begin
         if (p == PHASES - 1) calm = 1;
         program_register(ilp_pkg::REG_IDX_MODE, mode_plan[p]);
         program_register(ilp_pkg::REG_IDX_RADIX, radix_plan[p]);
         phase_end = words_sent + RANDOM_WORDS / PHASES;
         while (words_sent < phase_end) begin
            if ($urandom_range(0, 9) < 8) begin
               send_literal();
            end else begin
               send_word(8'($urandom_range(0, 255)), $urandom_range(0, 11) == 0);
            end
            // sender holds off until the block has caught up
            if (!calm && $urandom_range(0, 59) == 0) drain();
         end
         drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_numbers.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/ilp_pkg.sv
hdl/ilp_front.sv
hdl/ilp_queue.sv
hdl/ilp_back.sv
hdl/integer_literal_parser.sv
hdl/ilp_checker.sv
tb/integer_literal_parser_tb.sv
